// ===== hdl/dvsp_pkg.sv =====
`default_nettype none
package dvsp_pkg;

    localparam int PART_W = 20;
    localparam int COUNT_W = 3;
    localparam int DEF_MAX_PARTS = 4;
    localparam int OUT_PARTS = 4;
    localparam int MIN_PARTS = 2;

    localparam logic [PART_W-1:0] PART_LIMIT = 20'd999999;

    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_UPPER_V = 8'h56;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_AFTER_V,
        PH_PARTS,
        PH_TRAIL
    } phase_t;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } char_item_t;

    typedef struct packed {
        logic              valid_res;
        logic [PART_W-1:0] major;
        logic [PART_W-1:0] minor;
        logic [PART_W-1:0] patch;
        logic [PART_W-1:0] build;
        logic [COUNT_W-1:0] part_count;
    } res_item_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dotted_version_string_parser_core.sv =====
// the last character passes the input register, then its result is written to the result register, raising res_valid
// throughput: one character per cycle; the update is one multiply-by-ten accumulate
// and one part-store write between the input register and the result register
// a result waiting in the output register stalls only a following last character
// reset (rst_n low, asynchronous) clears the parse state, part store and both valid flags
`default_nettype none
module dotted_version_string_parser_core #(
    parameter int MAX_PARTS = dvsp_pkg::DEF_MAX_PARTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_ready,
    input  wire dvsp_pkg::char_item_t char_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output dvsp_pkg::res_item_t       res_data
);

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int ACC_W = dvsp_pkg::PART_W + 4;

    // input register
    logic                 in_vld_reg;
    dvsp_pkg::char_item_t in_data_reg;

    // parse state
    dvsp_pkg::phase_t              phase_reg, phase_next;
    logic                          err_reg, err_next;
    logic [dvsp_pkg::PART_W-1:0]   cur_reg, cur_next;
    logic                          dig_reg, dig_next;
    logic [dvsp_pkg::PART_W-1:0]   store_reg [MAX_PARTS];
    logic [dvsp_pkg::PART_W-1:0]   store_next [MAX_PARTS];
    logic [CNT_W-1:0]              done_reg, done_next;

    // result register
    logic                res_vld_reg;
    dvsp_pkg::res_item_t res_data_reg, res_data_next;

    logic advance;
    logic [7:0] c;
    logic body;
    logic dot_finish;
    logic end_finish;
    logic [ACC_W-1:0] acc;
    logic [dvsp_pkg::PART_W-1:0] outp [dvsp_pkg::OUT_PARTS];

    assign c = in_data_reg.character;
    // a non-last character never produces a result, so it need not wait on the output
    assign advance = in_vld_reg && (!in_data_reg.is_last || !res_vld_reg || res_ready);
    assign char_ready = !in_vld_reg || advance;
    assign res_valid = res_vld_reg;
    assign res_data = res_data_reg;

    assign acc = {1'b0, cur_reg, 3'b000} + {3'b000, cur_reg, 1'b0}
                 + {{(ACC_W-4){1'b0}}, 4'(c - dvsp_pkg::CH_ZERO)};

    always_comb
    begin
        phase_next = phase_reg;
        err_next = err_reg;
        cur_next = cur_reg;
        dig_next = dig_reg;
        store_next = store_reg;
        done_next = done_reg;
        body = 1'b0;
        dot_finish = 1'b0;
        end_finish = 1'b0;
        res_data_next = '0;
        for (int k = 0; k < dvsp_pkg::OUT_PARTS; k++)
        begin
            outp[k] = '0;
        end

        unique case (phase_reg)
            dvsp_pkg::PH_LEAD:
            begin
                if (dvsp_pkg::is_ws(c))
                begin
                    phase_next = dvsp_pkg::PH_LEAD;
                end
                else if (c == dvsp_pkg::CH_LOWER_V || c == dvsp_pkg::CH_UPPER_V)
                begin
                    phase_next = dvsp_pkg::PH_AFTER_V;
                end
                else
                begin
                    phase_next = dvsp_pkg::PH_PARTS;
                    body = 1'b1;
                end
            end
            dvsp_pkg::PH_AFTER_V:
            begin
                if (dvsp_pkg::is_ws(c))
                begin
                    phase_next = dvsp_pkg::PH_TRAIL;
                end
                else
                begin
                    phase_next = dvsp_pkg::PH_PARTS;
                    body = 1'b1;
                end
            end
            dvsp_pkg::PH_PARTS:
            begin
                body = 1'b1;
            end
            dvsp_pkg::PH_TRAIL:
            begin
                if (!dvsp_pkg::is_ws(c))
                begin
                    err_next = 1'b1;
                end
            end
            default:
            begin
                err_next = 1'b1;
            end
        endcase

        if (body)
        begin
            if (dvsp_pkg::is_digit(c))
            begin
                // saturate so the accumulator stays within the part width
                if (acc > ACC_W'(dvsp_pkg::PART_LIMIT))
                begin
                    err_next = 1'b1;
                    cur_next = dvsp_pkg::PART_LIMIT;
                end
                else
                begin
                    cur_next = acc[dvsp_pkg::PART_W-1:0];
                end
                dig_next = 1'b1;
            end
            else if (c == dvsp_pkg::CH_DOT)
            begin
                dot_finish = 1'b1;
            end
            else if (dvsp_pkg::is_ws(c))
            begin
                phase_next = dvsp_pkg::PH_TRAIL;
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        if (in_data_reg.is_last)
        begin
            if (phase_next == dvsp_pkg::PH_LEAD)
            begin
                err_next = 1'b1;
            end
            else
            begin
                end_finish = 1'b1;
            end
        end

        // a dot on the last character closes an empty part right after it
        if (dot_finish && end_finish)
        begin
            err_next = 1'b1;
        end

        if (dot_finish || end_finish)
        begin
            if (!dig_next)
            begin
                err_next = 1'b1;
            end
            else if (done_reg >= CNT_W'(MAX_PARTS))
            begin
                err_next = 1'b1;
            end
            else
            begin
                store_next[done_reg[IDX_W-1:0]] = cur_next;
                done_next = done_reg + 1'b1;
            end
            cur_next = '0;
            dig_next = 1'b0;
        end

        if (in_data_reg.is_last)
        begin
            if (done_next < CNT_W'(dvsp_pkg::MIN_PARTS))
            begin
                err_next = 1'b1;
            end
            for (int k = 0; k < dvsp_pkg::OUT_PARTS; k++)
            begin
                if (k < MAX_PARTS)
                begin
                    outp[k] = store_next[IDX_W'(k)];
                end
            end
            if (!err_next)
            begin
                res_data_next.valid_res = 1'b1;
                res_data_next.major = outp[0];
                res_data_next.minor = outp[1];
                res_data_next.patch = outp[2];
                res_data_next.build = outp[3];
                res_data_next.part_count = dvsp_pkg::COUNT_W'(done_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
            phase_reg <= dvsp_pkg::PH_LEAD;
            err_reg <= 1'b0;
            cur_reg <= '0;
            dig_reg <= 1'b0;
            done_reg <= '0;
            for (int k = 0; k < MAX_PARTS; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else
        begin
            if (char_ready)
            begin
                in_vld_reg <= char_valid;
            end

            if (advance && in_data_reg.is_last)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_data_reg.is_last)
                begin
                    // string done: back to the reset state
                    phase_reg <= dvsp_pkg::PH_LEAD;
                    err_reg <= 1'b0;
                    cur_reg <= '0;
                    dig_reg <= 1'b0;
                    done_reg <= '0;
                    for (int k = 0; k < MAX_PARTS; k++)
                    begin
                        store_reg[k] <= '0;
                    end
                end
                else
                begin
                    phase_reg <= phase_next;
                    err_reg <= err_next;
                    cur_reg <= cur_next;
                    dig_reg <= dig_next;
                    done_reg <= done_next;
                    store_reg <= store_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            in_data_reg <= char_data;
        end
        if (advance && in_data_reg.is_last)
        begin
            res_data_reg <= res_data_next;
        end
    end

`ifndef SYNTHESIS
    a_fail_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_data_reg.valid_res) |->
            (res_data_reg.major == '0 && res_data_reg.minor == '0 &&
             res_data_reg.patch == '0 && res_data_reg.build == '0 &&
             res_data_reg.part_count == '0))
        else $error("failed parse carries nonzero fields");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.is_last) |=>
            (phase_reg == dvsp_pkg::PH_LEAD && done_reg == '0 && !err_reg &&
             res_vld_reg))
        else $error("parser did not restart after the last character");

    a_no_digits_zero_part: assert property (@(posedge clk) disable iff (!rst_n)
        !dig_reg |-> (cur_reg == '0))
        else $error("part accumulator nonzero without digits");

    a_part_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg <= dvsp_pkg::PART_LIMIT) && (done_reg <= CNT_W'(MAX_PARTS)))
        else $error("part accumulator or part count out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/dotted_version_string_parser_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module dotted_version_string_parser_core_tb;

    localparam int FIELD_CAP = dvsp_pkg::DEF_MAX_PARTS;
    localparam int RANDOM_CHARS = 485;
    localparam int CALM_FROM = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_ROWS = 11;

    typedef struct {
        string               text;
        bit                  typed;
        dvsp_pkg::res_item_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_ready;
    dvsp_pkg::char_item_t char_data = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    dvsp_pkg::res_item_t  res_data;

    // parse state of the version predictor
    dvsp_pkg::phase_t            scan_phase;
    bit                          scan_bad;
    logic [dvsp_pkg::PART_W-1:0] part_acc;
    bit                          part_has_digit;
    logic [dvsp_pkg::PART_W-1:0] part_vals [FIELD_CAP];
    int unsigned                 part_total;

    dvsp_pkg::res_item_t parsed_q [$];
    logic [7:0]  text_q [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          sink_quiet = 1'b0;
    bit          idle_on = 1'b1;
    bit          calm = 1'b0;

    // '#' in a row stands for a NUL byte
    dir_row_t dir_rows [N_ROWS] = '{
        '{" \t\n\013\014\015", 1'b1, '0},
        '{"V", 1'b1, '0},
        '{"1 .2", 1'b1, '0},
        '{".1", 1'b1, '0},
        '{"1..2", 1'b1, '0},
        '{"1.", 1'b1, '0},
        '{"999999.0", 1'b1, '{1'b1, 20'd999999, 20'd0, 20'd0, 20'd0, 3'd2}},
        '{"1000000.1", 1'b1, '0},
        '{"0.0.0.0.0", 1'b1, '0},
        '{"V1.2.3.4 ", 1'b1, '{1'b1, 20'd1, 20'd2, 20'd3, 20'd4, 3'd4}},
        '{" v007.0012\t", 1'b0, '0}
    };

    dotted_version_string_parser_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return dvsp_pkg::CH_SPACE;
            1: return dvsp_pkg::CH_TAB;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return dvsp_pkg::CH_CR;
        endcase
    endfunction

    task automatic clear_parse();
        scan_phase = dvsp_pkg::PH_LEAD;
        scan_bad = 1'b0;
        part_acc = '0;
        part_has_digit = 1'b0;
        part_total = 0;
        for (int k = 0; k < FIELD_CAP; k++)
            part_vals[k] = '0;
    endtask

    task automatic close_part();
        if (!part_has_digit)
            scan_bad = 1'b1;
        else if (part_total >= FIELD_CAP)
            scan_bad = 1'b1;
        else
        begin
            part_vals[part_total] = part_acc;
            part_total++;
        end
        part_acc = '0;
        part_has_digit = 1'b0;
    endtask

    task automatic take_body(input logic [7:0] c);
        int unsigned v;
        if (c >= dvsp_pkg::CH_ZERO && c <= dvsp_pkg::CH_NINE)
        begin
            v = part_acc * 10 + (c - dvsp_pkg::CH_ZERO);
            // accumulator saturates at the part limit
            if (v > dvsp_pkg::PART_LIMIT)
            begin
                scan_bad = 1'b1;
                v = dvsp_pkg::PART_LIMIT;
            end
            part_acc = v[dvsp_pkg::PART_W-1:0];
            part_has_digit = 1'b1;
        end
        else if (c == dvsp_pkg::CH_DOT)
            close_part();
        else if (is_blank(c))
            scan_phase = dvsp_pkg::PH_TRAIL;
        else
            scan_bad = 1'b1;
    endtask

    task automatic parse_version_char(input logic [7:0] c, input bit last,
                                      output bit fire, output dvsp_pkg::res_item_t r);
        r = '0;
        fire = last;
        case (scan_phase)
            dvsp_pkg::PH_LEAD:
                if (is_blank(c))
                    ;
                else if (c == dvsp_pkg::CH_LOWER_V || c == dvsp_pkg::CH_UPPER_V)
                    scan_phase = dvsp_pkg::PH_AFTER_V;
                else
                begin
                    scan_phase = dvsp_pkg::PH_PARTS;
                    take_body(c);
                end
            dvsp_pkg::PH_AFTER_V:
                if (is_blank(c))
                    scan_phase = dvsp_pkg::PH_TRAIL;
                else
                begin
                    scan_phase = dvsp_pkg::PH_PARTS;
                    take_body(c);
                end
            dvsp_pkg::PH_PARTS:
                take_body(c);
            default:
                if (!is_blank(c))
                    scan_bad = 1'b1;
        endcase
        if (last)
        begin
            if (scan_phase == dvsp_pkg::PH_LEAD)
                scan_bad = 1'b1;
            else
                close_part();
            if (part_total < dvsp_pkg::MIN_PARTS)
                scan_bad = 1'b1;
            if (!scan_bad)
            begin
                r.valid_res = 1'b1;
                r.major = part_vals[0];
                r.minor = part_vals[1];
                r.patch = part_vals[2];
                r.build = part_vals[3];
                r.part_count = part_total[dvsp_pkg::COUNT_W-1:0];
            end
            clear_parse();
        end
    endtask

    task automatic push_char(input logic [7:0] c, input bit last,
                             output bit fire, output dvsp_pkg::res_item_t r);
        if (idle_on && !calm && $urandom_range(0, 5) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data <= dvsp_pkg::char_item_t'{c, last};
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        parse_version_char(c, last, fire, r);
    endtask

    task automatic send_text(input bit typed, input dvsp_pkg::res_item_t want);
        bit                  fire;
        dvsp_pkg::res_item_t r;
        for (int i = 0; i < text_q.size(); i++)
        begin
            push_char(text_q[i], i == text_q.size() - 1, fire, r);
            if (fire)
                parsed_q.insert(parsed_q.size(), typed ? want : r);
        end
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            text_q.insert(text_q.size(), dvsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic build_random_text();
        int n_parts;
        int kind;
        int pos;
        text_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // plain noise
            repeat ($urandom_range(1, 6))
                text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    text_q.insert(text_q.size(), pick_blank());
            if ($urandom_range(0, 3) == 0)
                text_q.insert(text_q.size(),
                              $urandom_range(0, 1) ? dvsp_pkg::CH_LOWER_V
                                                   : dvsp_pkg::CH_UPPER_V);
            case ($urandom_range(0, 9))
                0: n_parts = 1;
                1: n_parts = FIELD_CAP + 1;
                default: n_parts = $urandom_range(dvsp_pkg::MIN_PARTS, FIELD_CAP);
            endcase
            for (int p = 0; p < n_parts; p++)
            begin
                if (p != 0)
                    text_q.insert(text_q.size(), dvsp_pkg::CH_DOT);
                kind = $urandom_range(0, 11);
                if (kind == 0)
                    repeat (6) text_q.insert(text_q.size(), dvsp_pkg::CH_NINE);
                else if (kind == 1)
                begin
                    text_q.insert(text_q.size(), dvsp_pkg::CH_ZERO + 8'd1);
                    repeat (6) text_q.insert(text_q.size(), dvsp_pkg::CH_ZERO);
                end
                else if (kind == 2)
                    push_digits(7);
                else
                    push_digits($urandom_range(1, kind < 5 ? 6 : 3));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    text_q.insert(text_q.size(), pick_blank());
            // break the sequence now and then
            if ($urandom_range(0, 3) == 0)
            begin
                pos = $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_q[pos] = 8'($urandom_range(0, 255));
                    1: text_q.insert(pos, 8'($urandom_range(0, 255)));
                    2: if (text_q.size() > 1) text_q.delete(pos);
                    default: text_q.insert(pos, pick_blank());
                endcase
            end
        end
    endtask

    // result side: ready stalls and the check against the oldest expectation
    always @(posedge clk)
    begin
        dvsp_pkg::res_item_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            if (rst_n && res_valid && res_ready)
            begin
                if (parsed_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: valid=%0d %0d.%0d.%0d.%0d n=%0d",
                                 res_data.valid_res, res_data.major, res_data.minor,
                                 res_data.patch, res_data.build, res_data.part_count);
                end
                else
                begin
                    want = parsed_q.pop_front();
                    if (res_data !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: want valid=%0d %0d.%0d.%0d.%0d n=%0d",
                                     want.valid_res, want.major, want.minor,
                                     want.patch, want.build, want.part_count);
                            $display("          got  valid=%0d %0d.%0d.%0d.%0d n=%0d",
                                     res_data.valid_res, res_data.major, res_data.minor,
                                     res_data.patch, res_data.build, res_data.part_count);
                        end
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                sink_quiet = !sink_quiet;
            if (calm || sink_quiet)
            begin
                stall_left = 0;
                res_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    initial
    begin
        int         rand_chars;
        logic [7:0] ch;
        rand_chars = 0;
        clear_parse();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            text_q.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++)
            begin
                ch = dir_rows[r].text[i];
                if (ch == "#")
                    ch = 8'h00;
                text_q.insert(text_q.size(), ch);
            end
            send_text(dir_rows[r].typed, dir_rows[r].want);
        end

        while (rand_chars < RANDOM_CHARS)
        begin
            build_random_text();
            rand_chars += text_q.size();
            calm = rand_chars >= CALM_FROM;
            idle_on = $urandom_range(0, 2) != 0;
            send_text(1'b0, '0);
        end
        char_valid <= 1'b0;

        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
